// ===== rtl/ufs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ufs_pkg;

  localparam int unsigned IDX_W           = 10;
  localparam int unsigned CNT_W           = 11;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned APB_ADDR_W      = 2;
  localparam int unsigned APB_DATA_W      = 32;
  localparam int unsigned MAX_ELEMENTS_DEF = 1024;

  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic [APB_ADDR_W-1:0] REG_ADDR_COUNT = 2'd0;

  localparam logic [OP_W-1:0] OP_UNION     = 2'd0;
  localparam logic [OP_W-1:0] OP_CONNECTED = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND      = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] elem_a;
    logic [IDX_W-1:0] elem_b;
  } ufs_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] root_a;
    logic [IDX_W-1:0] root_b;
    logic             same_set;
    logic             merged;
    logic             range_error;
  } ufs_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/union_find_by_size_unit.sv =====
// Disjoint-set engine: weighted union by size with path halving.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one word per
// operation: union, connected query or find. Output channel
// (out_valid_o/out_ready_i/out_data_o) returns one word per operation.
// element_count is written over the APB port at byte address 0.
// One item at a time. A find walks the tree in halving steps, each one
// parent read and one grandparent read of the parent memory; a connected
// query walks a second time from elem_b, and a linking union then reads
// both root sizes. An out-of-range index answers without a walk. The
// single read port of the parent memory puts these reads one after
// another. The engine is ready for the next word in the cycle after the
// result leaves the engine for the output register.
// After reset a clearing pass over all MAX_ELEMENTS entries loads the tables;
// in_ready_o stays low until it ends, APB writes are taken throughout.
// If the receiver stalls, the result holds in the output register and
// the engine still takes and works one further word, then waits.
`timescale 1ns / 1ps
`default_nettype none

module union_find_by_size_unit #(
  parameter int unsigned MAX_ELEMENTS = ufs_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ufs_pkg::ufs_req_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ufs_pkg::ufs_rsp_t              out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ufs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ufs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ufs_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import ufs_pkg::*;

  logic [CNT_W-1:0] count;
  logic             rsp_valid, rsp_ready;
  ufs_rsp_t         rsp;

  logic             out_valid_q, out_valid_d;
  ufs_rsp_t         out_data_q, out_data_d;

  ufs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .count_o (count)
  );

  ufs_core #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .count_i     (count),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_data_i),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  assign rsp_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (rsp_valid && rsp_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = rsp;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.range_error) |->
      (!out_data_o.merged && !out_data_o.same_set &&
       out_data_o.root_a == '0 && out_data_o.root_b == '0))
    else $error("range error word carries data");

  a_merge_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.merged) |->
      (!out_data_o.same_set && out_data_o.root_a != out_data_o.root_b))
    else $error("merge reported on one tree");

  a_same_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.same_set) |-> (out_data_o.root_a == out_data_o.root_b))
    else $error("same set with differing roots");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second word taken while busy");
`endif

endmodule

`default_nettype wire

// ===== rtl/ufs_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ufs_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ufs_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [ufs_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [ufs_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready,
  output logic [ufs_pkg::CNT_W-1:0]            count_o
);
  import ufs_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    count_d = count_q;
    if (wr_en) begin
      count_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else begin
      count_q <= count_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_ADDR_COUNT) begin
      prdata = APB_DATA_W'(count_q);
    end
  end

  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== rtl/ufs_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ufs_core #(
  parameter int unsigned MAX_ELEMENTS = ufs_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [ufs_pkg::CNT_W-1:0] count_i,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  ufs_pkg::ufs_req_t         req_i,
  output logic                      rsp_valid_o,
  input  logic                      rsp_ready_i,
  output ufs_pkg::ufs_rsp_t         rsp_o
);
  import ufs_pkg::*;

  localparam int unsigned IW    = $clog2(MAX_ELEMENTS);
  localparam int unsigned SW    = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned CMP_W = (SW > CNT_W) ? SW : CNT_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PAR   = 3'd2;
  localparam logic [2:0] S_GRAND = 3'd3;
  localparam logic [2:0] S_SZA   = 3'd4;
  localparam logic [2:0] S_SZB   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [IW-1:0]   clr_q, clr_d;
  logic [OP_W-1:0] op_q, op_d;
  logic [IW-1:0]   b_q, b_d;
  logic [IW-1:0]   x_q, x_d;
  logic            side_q, side_d;
  logic [IW-1:0]   ra_q, ra_d;
  logic [IW-1:0]   rb_q, rb_d;
  logic            same_q, same_d;
  logic            merged_q, merged_d;
  logic            err_q, err_d;
  logic [SW-1:0]   sza_q, sza_d;

  logic [IW-1:0]   parent_mem [MAX_ELEMENTS];
  logic [SW-1:0]   size_mem   [MAX_ELEMENTS];
  logic [IW-1:0]   prd_q;
  logic [SW-1:0]   srd_q;

  logic            p_we, s_we;
  logic [IW-1:0]   p_raddr, p_waddr, p_wdata;
  logic [IW-1:0]   s_raddr, s_waddr;
  logic [SW-1:0]   s_wdata;

  logic [CMP_W-1:0] act_cnt;
  logic             a_bad, b_bad;

  assign act_cnt = (CMP_W'(count_i) > CMP_W'(MAX_ELEMENTS)) ? CMP_W'(MAX_ELEMENTS)
                                                             : CMP_W'(count_i);
  assign a_bad   = CMP_W'(req_i.elem_a) >= act_cnt;
  assign b_bad   = CMP_W'(req_i.elem_b) >= act_cnt;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    op_d        = op_q;
    b_d         = b_q;
    x_d         = x_q;
    side_d      = side_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    same_d      = same_q;
    merged_d    = merged_q;
    err_d       = err_q;
    sza_d       = sza_q;
    p_raddr     = x_q;
    s_raddr     = ra_q;
    p_we        = 1'b0;
    s_we        = 1'b0;
    p_waddr     = x_q;
    p_wdata     = prd_q;
    s_waddr     = ra_q;
    s_wdata     = '0;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        p_we    = 1'b1;
        s_we    = 1'b1;
        p_waddr = clr_q;
        p_wdata = clr_q;
        s_waddr = clr_q;
        s_wdata = SW'(1);
        clr_d   = IW'(clr_q + 1'b1);
        if (clr_q == IW'(MAX_ELEMENTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        p_raddr     = IW'(req_i.elem_a);
        if (req_valid_i) begin
          op_d     = req_i.op;
          x_d      = IW'(req_i.elem_a);
          b_d      = IW'(req_i.elem_b);
          side_d   = 1'b0;
          ra_d     = '0;
          rb_d     = '0;
          same_d   = 1'b0;
          merged_d = 1'b0;
          err_d    = 1'b0;
          case (req_i.op) inside
            OP_UNION, OP_CONNECTED: begin
              if (a_bad || b_bad) begin
                err_d   = 1'b1;
                state_d = S_DONE;
              end else begin
                state_d = S_PAR;
              end
            end
            OP_FIND: begin
              if (a_bad) begin
                err_d   = 1'b1;
                state_d = S_DONE;
              end else begin
                state_d = S_PAR;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_PAR: begin
        if (prd_q == x_q) begin
          if (!side_q) begin
            ra_d = x_q;
            if (op_q == OP_FIND) begin
              state_d = S_DONE;
            end else begin
              side_d  = 1'b1;
              x_d     = b_q;
              p_raddr = b_q;
            end
          end else begin
            rb_d   = x_q;
            same_d = (ra_q == x_q);
            if (op_q == OP_UNION && ra_q != x_q) begin
              s_raddr = ra_q;
              state_d = S_SZA;
            end else begin
              state_d = S_DONE;
            end
          end
        end else begin
          p_raddr = prd_q;
          state_d = S_GRAND;
        end
      end
      S_GRAND: begin
        p_we    = 1'b1;
        p_waddr = x_q;
        p_wdata = prd_q;
        x_d     = prd_q;
        p_raddr = prd_q;
        state_d = S_PAR;
      end
      S_SZA: begin
        sza_d   = srd_q;
        s_raddr = rb_q;
        state_d = S_SZB;
      end
      S_SZB: begin
        merged_d = 1'b1;
        p_we     = 1'b1;
        s_we     = 1'b1;
        s_wdata  = SW'(sza_q + srd_q);
        if (sza_q < srd_q) begin
          p_waddr = ra_q;
          p_wdata = rb_q;
          s_waddr = rb_q;
        end else begin
          p_waddr = rb_q;
          p_wdata = ra_q;
          s_waddr = ra_q;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    b_q      <= b_d;
    x_q      <= x_d;
    side_q   <= side_d;
    ra_q     <= ra_d;
    rb_q     <= rb_d;
    same_q   <= same_d;
    merged_q <= merged_d;
    err_q    <= err_d;
    sza_q    <= sza_d;
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      parent_mem[p_waddr] <= p_wdata;
    end
    prd_q <= parent_mem[p_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      size_mem[s_waddr] <= s_wdata;
    end
    srd_q <= size_mem[s_raddr];
  end

  assign rsp_o.root_a      = IDX_W'(ra_q);
  assign rsp_o.root_b      = IDX_W'(rb_q);
  assign rsp_o.same_set    = same_q;
  assign rsp_o.merged      = merged_q;
  assign rsp_o.range_error = err_q;

endmodule

`default_nettype wire

// ===== tb/tb_union_find_by_size_unit.sv =====
`timescale 1ns / 1ps

module tb_union_find_by_size_unit;
  import ufs_pkg::*;

  localparam int unsigned ELEMS = MAX_ELEMENTS_DEF;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int unsigned IDLE_LIMIT = 6000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned NUM_PHASES = 10;

  class uf_scoreboard;
    logic [IDX_W-1:0] parent_tbl [ELEMS];
    logic [CNT_W-1:0] size_tbl [ELEMS];
    logic [CNT_W-1:0] elem_count;
    ufs_rsp_t pending [$];
    int errors;

    function new();
      foreach (parent_tbl[k]) begin
        parent_tbl[k] = IDX_W'(k);
        size_tbl[k] = CNT_W'(1);
      end
      elem_count = COUNT_RESET;
      errors = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] value);
      elem_count = value;
    endfunction

    // halve the path while climbing
    function logic [IDX_W-1:0] walk_root(logic [IDX_W-1:0] x);
      while (parent_tbl[x] != x) begin
        parent_tbl[x] = parent_tbl[parent_tbl[x]];
        x = parent_tbl[x];
      end
      return x;
    endfunction

    function void note_request(ufs_req_t w);
      ufs_rsp_t r;
      logic [CNT_W-1:0] lim;
      logic [IDX_W-1:0] ra;
      logic [IDX_W-1:0] rb;
      r = '0;
      lim = (elem_count > ELEMS) ? CNT_W'(ELEMS) : elem_count;
      case (w.op)
        OP_UNION, OP_CONNECTED: begin
          if ({1'b0, w.elem_a} >= lim || {1'b0, w.elem_b} >= lim) begin
            r.range_error = 1'b1;
          end else begin
            ra = walk_root(w.elem_a);
            rb = walk_root(w.elem_b);
            r.root_a = ra;
            r.root_b = rb;
            r.same_set = (ra == rb);
            if (w.op == OP_UNION && ra != rb) begin
              if (size_tbl[ra] < size_tbl[rb]) begin
                parent_tbl[ra] = rb;
                size_tbl[rb] = size_tbl[rb] + size_tbl[ra];
              end else begin
                parent_tbl[rb] = ra;
                size_tbl[ra] = size_tbl[ra] + size_tbl[rb];
              end
              r.merged = 1'b1;
            end
          end
        end
        OP_FIND: begin
          if ({1'b0, w.elem_a} >= lim) r.range_error = 1'b1;
          else r.root_a = walk_root(w.elem_a);
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] %s", $time, msg);
    endtask

    task check_result(ufs_rsp_t got);
      ufs_rsp_t want;
      if (pending.size() == 0) begin
        report("result word with nothing pending");
        return;
      end
      want = pending.pop_front();
      if (got.root_a !== want.root_a)
        report($sformatf("root_a got %0d want %0d", got.root_a, want.root_a));
      if (got.root_b !== want.root_b)
        report($sformatf("root_b got %0d want %0d", got.root_b, want.root_b));
      if (got.same_set !== want.same_set)
        report($sformatf("same_set got %b want %b", got.same_set, want.same_set));
      if (got.merged !== want.merged)
        report($sformatf("merged got %b want %b", got.merged, want.merged));
      if (got.range_error !== want.range_error)
        report($sformatf("range_error got %b want %b", got.range_error, want.range_error));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  ufs_req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  ufs_rsp_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  uf_scoreboard sb = new();
  bit hold_due = 1'b0;
  int send_calm = 0;
  int recv_calm = 0;
  int unsigned idle_cycles = 0;

  int unsigned phase_count [NUM_PHASES] = '{16, 1024, 64, 0, 200, 2047, 1, 1024, 37, 1000};
  int unsigned phase_items [NUM_PHASES] = '{120, 150, 120, 20, 120, 100, 20, 120, 80, 100};

  union_find_by_size_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #6 clk_i = ~clk_i;

  // random gaps, broken by runs with none
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(int unsigned lim);
    if (lim == 0 || $urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, ELEMS - 1));
    case ($urandom_range(0, 19))
      0: return '0;
      1: return IDX_W'(lim - 1);
      default: return IDX_W'($urandom_range(0, lim - 1));
    endcase
  endfunction

  function automatic ufs_req_t random_word(int unsigned count);
    ufs_req_t w;
    int unsigned lim;
    int unsigned pick;
    lim = (count > ELEMS) ? ELEMS : count;
    pick = $urandom_range(0, 99);
    if (pick < 45) w.op = OP_UNION;
    else if (pick < 70) w.op = OP_CONNECTED;
    else if (pick < 95) w.op = OP_FIND;
    else w.op = OP_SPARE;
    w.elem_a = pick_index(lim);
    w.elem_b = pick_index(lim);
    return w;
  endfunction

  task automatic send_word(ufs_req_t w);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    sb.note_request(w);
  endtask

  task automatic send_op(logic [OP_W-1:0] op, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    ufs_req_t w;
    w.op = op;
    w.elem_a = a;
    w.elem_b = b;
    send_word(w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CNT_W-1:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_ADDR_COUNT;
    pwdata <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_count(value);
  endtask

  task automatic run_directed();
    send_op(OP_FIND, 10'd0, 10'd1023);
    send_op(OP_FIND, 10'd1023, 10'd0);
    send_op(OP_CONNECTED, 10'd0, 10'd1023);
    send_op(OP_UNION, 10'd0, 10'd1023);
    send_op(OP_UNION, 10'd1023, 10'd0);
    send_op(OP_CONNECTED, 10'd1023, 10'd0);
    send_op(OP_FIND, 10'd1023, 10'd1023);
    send_op(OP_UNION, 10'd5, 10'd6);
    send_op(OP_UNION, 10'd7, 10'd5);
    send_op(OP_UNION, 10'd5, 10'd7);
    send_op(OP_UNION, 10'd1, 10'd2);
    send_op(OP_UNION, 10'd3, 10'd4);
    send_op(OP_UNION, 10'd2, 10'd4);
    send_op(OP_UNION, 10'd1, 10'd5);
    send_op(OP_FIND, 10'd7, 10'd0);
    send_op(OP_FIND, 10'd7, 10'd0);
    send_op(OP_SPARE, 10'd1023, 10'd1023);
    send_op(OP_SPARE, 10'd0, 10'd0);
    write_count(11'd512);
    send_op(OP_UNION, 10'd600, 10'd1);
    send_op(OP_CONNECTED, 10'd1, 10'd700);
    send_op(OP_FIND, 10'd1, 10'd1023);
    send_op(OP_FIND, 10'd511, 10'd0);
    send_op(OP_FIND, 10'd512, 10'd0);
    write_count(11'd0);
    send_op(OP_FIND, 10'd0, 10'd0);
    send_op(OP_UNION, 10'd0, 10'd0);
    write_count(11'd2047);
    send_op(OP_FIND, 10'd1023, 10'd0);
    send_op(OP_UNION, 10'd1023, 10'd1022);
  endtask

  initial begin
    int gap;
    forever begin
      gap = draw_gap(recv_calm);
      if (hold_due) begin
        hold_due = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      sb.check_result(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("union_find_by_size_unit: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_count(CNT_W'(phase_count[p]));
      if (p == 1) hold_due = 1'b1;
      for (int n = 0; n < phase_items[p]; n++) send_word(random_word(phase_count[p]));
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("union_find_by_size_unit: match");
    end else begin
      $display("union_find_by_size_unit: mismatch");
    end
    $finish;
  end

endmodule
